// File: rtl/core/dms_pkg.sv
// shared types and constants for the dimension membership set unit
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

	localparam int MAX_CELLS_DEF = 16;
	localparam int CELL_BITS_DEF = 16;
	localparam int DIM_W         = 16;
	localparam int COUNT_W       = 5;

	typedef enum logic [2:0] {
		ACT_ADD      = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_CLEAR    = 3'd2,
		ACT_CONTAINS = 3'd3,
		ACT_SHARE    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_LOOKUP = 1'b1
	} state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [DIM_W-1:0]   dimension;
		logic [COUNT_W-1:0] other_count;
		logic               last;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [1:0]         status;
		logic [DIM_W-1:0]   main_dimension;
		logic [COUNT_W-1:0] dimension_count;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dms_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/dms_ctrl.sv
// controller state machine: request capture, result commit and output valid
`timescale 1ns / 1ps
`default_nettype none

module dms_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output dms_pkg::dms_cmd_t      cmd
);

	dms_pkg::state_t state_q;
	dms_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dms_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = dms_pkg::S_LOOKUP;
				end
			end
			dms_pkg::S_LOOKUP: begin
				if (slot_free) begin
					state_d = dms_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dms_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			dms_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			dms_pkg::S_LOOKUP: begin
				cmd.commit = slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dms_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_commit_only_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> state_q == dms_pkg::S_LOOKUP)
		else $error("commit outside lookup");

	a_capture_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == dms_pkg::S_LOOKUP)
		else $error("capture did not enter lookup");

	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("commit lost result");

endmodule

`default_nettype wire

// File: rtl/core/dms_datapath.sv
// cell store, parallel match, set update and result register
`timescale 1ns / 1ps
`default_nettype none

module dms_datapath #(
	parameter int MAX_CELLS = dms_pkg::MAX_CELLS_DEF,
	parameter int CELL_BITS = dms_pkg::CELL_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dms_pkg::dms_cmd_t cmd,
	input  wire dms_pkg::req_t     req,
	output dms_pkg::rsp_t          rsp
);

	localparam int CNT_W = $clog2(MAX_CELLS + 1);
	localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic [CELL_BITS-1:0] store_q [MAX_CELLS];
	logic [CNT_W-1:0]     count_q;
	logic [CELL_BITS-1:0] main_q;
	logic                 acc_q;

	dms_pkg::action_t     action_s1;
	logic [CELL_BITS-1:0] id_s1;
	logic                 other_zero_s1;
	logic                 last_s1;
	logic [MAX_CELLS-1:0] match_s1;

	dms_pkg::rsp_t        rsp_q;

	logic [31:0]          dim_ext;
	logic [CELL_BITS-1:0] id_in;
	logic [MAX_CELLS-1:0] match_d;

	logic                 found;
	logic [IDX_W-1:0]     pos;
	logic [IDX_W-1:0]     last_idx;
	logic [CELL_BITS-1:0] last_val;
	logic                 acc_set;

	logic                 hit_d;
	dms_pkg::status_t     status_d;
	logic [CNT_W-1:0]     count_d;
	logic [CELL_BITS-1:0] main_d;
	logic                 acc_d;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [CELL_BITS-1:0] wr_data;
	logic [31:0]          main_ext;

	assign dim_ext = 32'(req.dimension);
	assign id_in   = dim_ext[CELL_BITS-1:0];

	always_comb begin
		for (int i = 0; i < MAX_CELLS; i++) begin
			match_d[i] = (CNT_W'(i) < count_q) && (store_q[i] == id_in);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_s1     <= dms_pkg::action_t'(req.action);
			id_s1         <= id_in;
			other_zero_s1 <= (req.other_count == '0);
			last_s1       <= req.last;
			match_s1      <= match_d;
		end
	end

	// ids are unique, so at most one match bit is set
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_CELLS; i++) begin
			if (match_s1[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign found    = |match_s1;
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign last_val = store_q[last_idx];
	assign acc_set  = acc_q || (!other_zero_s1 && found);

	always_comb begin
		hit_d    = 1'b0;
		status_d = dms_pkg::ST_OK;
		count_d  = count_q;
		main_d   = main_q;
		acc_d    = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = count_q[IDX_W-1:0];
		wr_data  = id_s1;
		case (action_s1)
			dms_pkg::ACT_ADD: begin
				if (found) begin
					status_d = dms_pkg::ST_PRESENT;
				end else if (count_q >= CNT_W'(MAX_CELLS)) begin
					status_d = dms_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (count_q == '0) begin
						main_d = id_s1;
					end
				end
			end
			dms_pkg::ACT_REMOVE: begin
				if (!found) begin
					status_d = dms_pkg::ST_ABSENT;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = pos;
					wr_data = last_val;
					count_d = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						main_d = '0;
					end else if (pos == '0) begin
						main_d = last_val;
					end
				end
			end
			dms_pkg::ACT_CLEAR: begin
				count_d = '0;
				main_d  = '0;
			end
			dms_pkg::ACT_CONTAINS: begin
				if (found) begin
					hit_d = 1'b1;
				end else begin
					status_d = dms_pkg::ST_ABSENT;
				end
			end
			dms_pkg::ACT_SHARE: begin
				if (last_s1) begin
					hit_d = (count_q == '0 && other_zero_s1) ? 1'b1 : acc_set;
				end else begin
					acc_d = acc_set;
				end
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
	end

	assign main_ext = 32'(main_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			main_q  <= '0;
			acc_q   <= 1'b0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			main_q  <= main_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.hit             <= hit_d;
			rsp_q.status          <= status_d;
			rsp_q.main_dimension  <= main_ext[dms_pkg::DIM_W-1:0];
			rsp_q.dimension_count <= dms_pkg::COUNT_W'(count_d);
		end
	end

	assign rsp = rsp_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CELLS))
		else $error("entry count above capacity");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(match_s1))
		else $error("duplicate id in store");

	a_empty_main_zero: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> main_q == '0)
		else $error("main id nonzero in empty set");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && action_s1 == dms_pkg::ACT_CLEAR |=> count_q == '0)
		else $error("clear left entries");

endmodule

`default_nettype wire

// File: rtl/core/dimension_membership_set_unit.sv
// top level of the dimension membership set unit
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------
//   request  | req_valid / req_ready    | req (action, dimension, ...)
//   response | rsp_valid / rsp_ready    | rsp (hit, status, main, count)
//
// each item is captured and compared against every stored entry in parallel,
// then the set is updated and the result register loaded
// one result per item, held in an output register until its transfer
// a response stalled by rsp_ready holds the unit in its update cycle
// reset clears count, main id and share state; stored entries need no reset
`timescale 1ns / 1ps
`default_nettype none

module dimension_membership_set_unit #(
	parameter int MAX_CELLS = dms_pkg::MAX_CELLS_DEF,
	parameter int CELL_BITS = dms_pkg::CELL_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire dms_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output dms_pkg::rsp_t      rsp
);

	dms_pkg::dms_cmd_t cmd;

	dms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	dms_datapath #(
		.MAX_CELLS (MAX_CELLS),
		.CELL_BITS (CELL_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: test/tb_dimension_membership_set_unit.sv
// testbench for the dimension membership set unit, checked against a cell set predictor
`timescale 1ns / 1ps

module tb_dimension_membership_set_unit;

	localparam int MAX_CELLS      = dms_pkg::MAX_CELLS_DEF;
	localparam int RANDOM_ITEMS   = 1900;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int LONG_HOLD      = 150;
	localparam int POOL_MAX       = 24;
	localparam logic [2:0] ACT_CODE_MAX = 3'd7;

	typedef struct {
		dms_pkg::req_t req;
		bit            drain_first;
	} req_item_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	dms_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	dms_pkg::rsp_t rsp;

	req_item_t     pending_reqs[$];
	dms_pkg::rsp_t expected_rsps[$];

	logic [dms_pkg::DIM_W-1:0]   set_ids[MAX_CELLS];
	logic [dms_pkg::COUNT_W-1:0] set_count  = '0;
	logic                        share_seen = 1'b0;

	logic [dms_pkg::DIM_W-1:0] id_pool[POOL_MAX];
	int pool_size  = 1;
	int items_made = 0;
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles  = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	bit tx_quiet     = 1'b0;
	bit rx_quiet     = 1'b0;

	dimension_membership_set_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int find_id(logic [dms_pkg::DIM_W-1:0] id);
		for (int i = 0; i < int'(set_count); i++) begin
			if (set_ids[i] == id) return i;
		end
		return -1;
	endfunction

	// updates the tracked set and returns the response the unit must give
	function automatic dms_pkg::rsp_t apply_request(dms_pkg::req_t r);
		dms_pkg::rsp_t o;
		int            pos;
		o = '0;
		if (r.action != dms_pkg::ACT_SHARE) share_seen = 1'b0;
		case (r.action)
			dms_pkg::ACT_ADD: begin
				if (find_id(r.dimension) >= 0) begin
					o.status = dms_pkg::ST_PRESENT;
				end else if (int'(set_count) >= MAX_CELLS) begin
					o.status = dms_pkg::ST_FULL;
				end else begin
					set_ids[set_count] = r.dimension;
					set_count = set_count + 1'b1;
				end
			end
			dms_pkg::ACT_REMOVE: begin
				pos = find_id(r.dimension);
				if (pos < 0) begin
					o.status = dms_pkg::ST_ABSENT;
				end else begin
					set_ids[pos] = set_ids[set_count - 1'b1];
					set_count = set_count - 1'b1;
				end
			end
			dms_pkg::ACT_CLEAR: begin
				set_count = '0;
			end
			dms_pkg::ACT_CONTAINS: begin
				if (find_id(r.dimension) >= 0) o.hit = 1'b1;
				else o.status = dms_pkg::ST_ABSENT;
			end
			dms_pkg::ACT_SHARE: begin
				if (r.other_count != '0 && find_id(r.dimension) >= 0)
					share_seen = 1'b1;
				if (r.last) begin
					if (set_count == '0 && r.other_count == '0) o.hit = 1'b1;
					else o.hit = share_seen;
					share_seen = 1'b0;
				end
			end
			default: ;
		endcase
		o.main_dimension  = (set_count != '0) ? set_ids[0] : '0;
		o.dimension_count = set_count;
		return o;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [dms_pkg::DIM_W-1:0] pick_id();
		if ($urandom_range(0, 9) == 0) return dms_pkg::DIM_W'($urandom);
		return id_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	task automatic queue_req(logic [2:0] act, logic [dms_pkg::DIM_W-1:0] dim,
			logic [dms_pkg::COUNT_W-1:0] cnt, logic lst);
		req_item_t it;
		it.req.action      = act;
		it.req.dimension   = dim;
		it.req.other_count = cnt;
		it.req.last        = lst;
		it.drain_first     = (items_made == 500 || items_made == 1200 ||
				$urandom_range(0, 199) == 0);
		pending_reqs.insert(pending_reqs.size(), it);
		items_made++;
	endtask

	task automatic queue_plain(logic [2:0] act);
		queue_req(act, pick_id(), dms_pkg::COUNT_W'($urandom_range(0, 16)), 1'($urandom));
	endtask

	// another entity's cell list; a broken stream never sets its last flag and may stop early
	task automatic queue_share_stream(bit broken);
		int n;
		int stop;
		n = $urandom_range(0, 16);
		if (n == 0) begin
			queue_req(dms_pkg::ACT_SHARE, dms_pkg::DIM_W'($urandom), '0, !broken);
		end else begin
			stop = broken ? $urandom_range(1, n) : n;
			for (int k = 0; k < stop; k++)
				queue_req(dms_pkg::ACT_SHARE, pick_id(), dms_pkg::COUNT_W'(n),
					!broken && k == n - 1);
		end
	endtask

	task automatic fill_pool();
		int r;
		case ($urandom_range(0, 3))
			0: pool_size = 2;
			1: pool_size = 6;
			2: pool_size = 12;
			default: pool_size = 20;
		endcase
		for (int i = 0; i < pool_size; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) id_pool[i] = '0;
			else if (r < 16) id_pool[i] = '1;
			else id_pool[i] = dms_pkg::DIM_W'($urandom);
		end
	endtask

	task automatic check_field(string field, int exp_val, int act_val);
		if (exp_val != act_val) begin
			if (mismatches < 10)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					results_seen, field, exp_val, act_val);
			mismatches++;
		end
	endtask

	// request side
	always @(posedge clk) begin
		req_item_t     nxt;
		logic          offer_next;
		dms_pkg::req_t next_req;
		if (arst_n) begin
			offer_next = req_valid;
			next_req   = req;
			if (req_valid && req_ready) begin
				expected_rsps.insert(expected_rsps.size(), apply_request(req));
				offer_next = 1'b0;
				send_gap   = pick_gap(tx_quiet);
			end
			if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
			if (!offer_next && pending_reqs.size() > 0) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (!pending_reqs[0].drain_first || expected_rsps.size() == 0) begin
					nxt        = pending_reqs.pop_front();
					next_req   = nxt.req;
					offer_next = 1'b1;
				end
			end
			req_valid <= offer_next;
			req       <= next_req;
		end
	end

	// response side
	always @(posedge clk) begin
		dms_pkg::rsp_t exp_rsp;
		logic          next_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d arrived with none expected: %p", results_seen, rsp);
					mismatches++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					check_field("hit", exp_rsp.hit, rsp.hit);
					check_field("status", exp_rsp.status, rsp.status);
					check_field("main_dimension", exp_rsp.main_dimension, rsp.main_dimension);
					check_field("dimension_count", exp_rsp.dimension_count,
						rsp.dimension_count);
				end
				results_seen++;
				if (results_seen == 400 || results_seen == 1300) hold_left = LONG_HOLD;
			end
			if ($urandom_range(0, 149) == 0) rx_quiet = !rx_quiet;
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else begin
				stall_left = pick_gap(rx_quiet);
				next_ready = (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
			rsp_ready <= next_ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int add_bias;
		int seg_len;
		int directed_items;

		// empty set corner cases, then adds of the extreme ids with contains and share checks
		queue_req(dms_pkg::ACT_SHARE, 16'h5a5a, '0, 1'b1);
		queue_req(dms_pkg::ACT_CONTAINS, 16'h0000, 5'd16, 1'b1);
		queue_req(dms_pkg::ACT_REMOVE, 16'hffff, '0, 1'b0);
		queue_req(dms_pkg::ACT_ADD, 16'h0000, '0, 1'b0);
		queue_req(dms_pkg::ACT_ADD, 16'hffff, 5'd31, 1'b1);
		queue_req(dms_pkg::ACT_ADD, 16'hffff, '0, 1'b0);
		queue_req(dms_pkg::ACT_CONTAINS, 16'hffff, '0, 1'b0);
		queue_req(dms_pkg::ACT_CONTAINS, 16'h1234, '0, 1'b0);
		queue_req(dms_pkg::ACT_SHARE, 16'hffff, 5'd1, 1'b1);
		queue_req(dms_pkg::ACT_SHARE, 16'h8000, 5'd2, 1'b0);
		queue_req(dms_pkg::ACT_SHARE, 16'h7fff, 5'd2, 1'b1);
		queue_req(dms_pkg::ACT_SHARE, 16'h0000, 5'd2, 1'b0);
		// interrupted stream, then swap remove of the main id, undefined action codes, clear and share
		queue_req(dms_pkg::ACT_REMOVE, 16'h0000, '0, 1'b0);
		queue_req(dms_pkg::ACT_SHARE, 16'h0000, '0, 1'b1);
		queue_req(3'(int'(dms_pkg::ACT_SHARE) + 1), 16'hffff, 5'd16, 1'b1);
		queue_req(ACT_CODE_MAX, 16'h0000, '0, 1'b0);
		queue_req(dms_pkg::ACT_CLEAR, 16'hffff, 5'd16, 1'b1);
		queue_req(dms_pkg::ACT_SHARE, 16'hffff, '0, 1'b1);
		directed_items = items_made;

		while (items_made < directed_items + RANDOM_ITEMS) begin
			fill_pool();
			add_bias = $urandom_range(25, 65);
			seg_len  = $urandom_range(15, 60);
			if ($urandom_range(0, 3) == 0) queue_plain(dms_pkg::ACT_CLEAR);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				if (r < add_bias) queue_plain(dms_pkg::ACT_ADD);
				else if (r < add_bias + 12) queue_plain(dms_pkg::ACT_REMOVE);
				else if (r < add_bias + 24) queue_plain(dms_pkg::ACT_CONTAINS);
				else if (r < add_bias + 34) queue_share_stream(1'b0);
				else if (r < add_bias + 36) queue_share_stream(1'b1);
				else if (r < add_bias + 38) queue_plain(dms_pkg::ACT_CLEAR);
				else if (r < add_bias + 39)
					queue_plain(3'($urandom_range(int'(dms_pkg::ACT_SHARE) + 1, ACT_CODE_MAX)));
				else queue_plain(dms_pkg::ACT_CONTAINS);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/dms_pkg.sv
rtl/core/dms_ctrl.sv
rtl/core/dms_datapath.sv
rtl/core/dimension_membership_set_unit.sv
test/tb_dimension_membership_set_unit.sv
